### rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_FRAMES_DEF   = 65536;
  localparam int RESERVED_LOW_DEF = 1024;
  localparam int WORD_BITS        = 64;
  localparam int FRAME_SHIFT      = 12;   // 4 KiB frames
  localparam int FN_W             = 53;   // frame number of a 64-bit address, plus carry
  localparam int ADDR_W           = 28;
  localparam int STATUS_W         = 2;

  typedef enum logic [2:0] {
    OP_MEASURE  = 3'd0,
    OP_MARK_ALL = 3'd1,
    OP_RELEASE  = 3'd2,
    OP_ALLOC    = 3'd3,
    OP_FREE     = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SWEEP,
    CMD_MEAS_SUM,
    CMD_MEAS_ROUND,
    CMD_MEAS_UPD,
    CMD_REL_START,
    CMD_REL_STOP,
    CMD_REL_CLIP,
    CMD_REL_SETUP,
    CMD_RMW_RD,
    CMD_REL_WR,
    CMD_SCAN,
    CMD_ALLOC_WR,
    CMD_FREE_RD,
    CMD_FREE_WR
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_MARK,
    ST_MEAS_SUM,
    ST_MEAS_ROUND,
    ST_MEAS_UPD,
    ST_REL_START,
    ST_REL_STOP,
    ST_REL_CLIP,
    ST_REL_SETUP,
    ST_REL_RD,
    ST_REL_WR,
    ST_SCAN,
    ST_ALLOC_WR,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] op;
    logic       type_avail;
    logic       sweep_last;
    logic       rel_empty;
    logic       rel_last;
    logic       scan_found;
    logic       scan_exhausted;
    logic       free_in_range;
  } dp_stat_t;

endpackage

### rtl/bitmap_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// Lowest-first bitmap allocator for 4 KiB physical frames.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the operation (measure, mark all used,
// release region, allocate, free frame), s_tdata the region and frame fields.
// Output stream: one item per input item with the allocated frame address
// and a status code. Items are handled one at a time. Measure sums, rounds
// and updates the frame count; free clears the bit if the index is in range;
// release of a non-available region goes straight to the result; release
// reads and rewrites each bitmap word it touches; mark all used sweeps every
// word; allocate scans up to the first word with a clear bit (at most
// WORD_COUNT = MAX_FRAMES/64 words, one read per cycle from the bitmap memory).
// After reset the bitmap memory is swept to all ones, one word per cycle
// over all WORD_COUNT words (1024 by default); s_tready stays low meanwhile.
// The result sits in an output register, so the next item is accepted
// while it waits; an item finished while the previous result is still
// stalled holds in the sequencer until m_tready takes that result.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES          = MAX_FRAMES_DEF,
  parameter int RESERVED_LOW_FRAMES = RESERVED_LOW_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,   // region_base, region_length, region_type, free_index
  input  logic [2:0]   s_tuser,   // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata    // frame_address, status, zero pad
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             out_free;
  logic             out_load;
  logic [ADDR_W-1:0] res_addr;
  status_t          res_status;
  logic [ADDR_W-1:0] out_addr;
  status_t          out_status;

  assign out_free = !m_tvalid || m_tready;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (s_tready),
    .out_load (out_load)
  );

  bfa_datapath #(
    .MAX_FRAMES          (MAX_FRAMES),
    .RESERVED_LOW_FRAMES (RESERVED_LOW_FRAMES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .operation     (s_tuser),
    .region_base   (s_tdata[63:0]),
    .region_length (s_tdata[95:64]),
    .region_type   (s_tdata[127:96]),
    .free_index    (s_tdata[143:128]),
    .stat          (stat),
    .res_addr      (res_addr),
    .res_status    (res_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr   <= res_addr;
      out_status <= res_status;
    end
  end

  assign m_tdata = {2'b00, out_status, out_addr};

endmodule

### rtl/bfa_datapath.sv
// ----------------------------------------------------------------------------
// bfa_datapath
// Bitmap memory, frame count, region arithmetic and word scan of the allocator.
// ----------------------------------------------------------------------------
module bfa_datapath
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES          = MAX_FRAMES_DEF,
  parameter int RESERVED_LOW_FRAMES = RESERVED_LOW_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  input  logic [2:0]    operation,
  input  logic [63:0]   region_base,
  input  logic [31:0]   region_length,
  input  logic [31:0]   region_type,
  input  logic [15:0]   free_index,
  output dp_stat_t      stat,
  output logic [ADDR_W-1:0] res_addr,
  output status_t       res_status
);

  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA         = $clog2(WORD_COUNT);
  localparam int IDX_W      = WA + 6;
  localparam int FC_W       = $clog2(MAX_FRAMES + 1);

  localparam logic [FN_W-1:0] MAX_FN = FN_W'(MAX_FRAMES);
  localparam logic [FN_W-1:0] RES_FN = FN_W'(RESERVED_LOW_FRAMES);
  localparam logic [WA-1:0]   LAST_WORD = WA'(WORD_COUNT - 1);
  localparam logic [WA:0]     WORD_END  = (WA+1)'(WORD_COUNT);

  // item registers
  logic [2:0]  op_r;
  logic [63:0] base_r;
  logic [31:0] len_r;
  logic [31:0] type_r;
  logic [15:0] fidx_r;

  logic [63:0]     end_r;
  logic [FN_W-1:0] rs;
  logic [FN_W-1:0] re;
  logic [FC_W-1:0] fc;
  logic [WA:0]     ptr;
  logic [IDX_W-1:0] lo_r;
  logic [IDX_W-1:0] hi_r;
  logic            rd_vld_q;
  logic [WA-1:0]   rd_word_q;
  logic [5:0]      fbit;
  logic [WA-1:0]   fword;
  logic [63:0]     fdata;

  logic [63:0] mem [WORD_COUNT];
  logic [63:0] rdata;
  logic        we;
  logic [WA-1:0] waddr;
  logic [63:0] wdata;
  logic [WA-1:0] raddr;

  logic [FN_W-1:0] fc_ext;
  logic [FN_W-1:0] fidx_ext;
  logic [WA-1:0]   free_word;
  logic [63:0]     free_bit;
  logic            free_in_range;
  logic [63:0]     inv;
  logic [63:0]     lowest;
  logic [5:0]      low_bit;
  logic            rd_full;
  logic            scan_found;
  logic            scan_exhausted;
  logic [IDX_W-1:0] alloc_idx;
  logic            alloc_ok;
  logic [IDX_W+ADDR_W+FRAME_SHIFT-1:0] alloc_wide;
  logic [63:0]     alloc_bit;
  logic [5:0]      lb;
  logic [5:0]      hb;
  logic [63:0]     rel_mask;
  logic            rel_last;
  logic            sweep_last;
  logic [FN_W-1:0] re_m1;
  logic [FN_W-1:0] cand;
  logic [FN_W-1:0] base_fn;

  assign fc_ext    = FN_W'(fc);
  assign fidx_ext  = FN_W'(fidx_r);
  assign free_word = fidx_ext[IDX_W-1:6];
  assign free_bit  = 64'd1 << fidx_r[5:0];
  assign free_in_range = fidx_ext < fc_ext;

  // lowest clear bit of the word just read
  assign inv     = ~rdata;
  assign lowest  = inv & (~inv + 64'd1);
  assign rd_full = &rdata;

  always_comb begin
    low_bit = '0;
    for (int k = 0; k < 6; k++) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (((b >> k) & 1) == 1) begin
          low_bit[k] = low_bit[k] | lowest[b];
        end
      end
    end
  end

  assign scan_found     = rd_vld_q && !rd_full;
  assign scan_exhausted = rd_vld_q && rd_full && (rd_word_q == LAST_WORD);

  assign alloc_idx  = {fword, fbit};
  assign alloc_ok   = FN_W'(alloc_idx) < fc_ext;
  assign alloc_wide = {{ADDR_W{1'b0}}, alloc_idx, {FRAME_SHIFT{1'b0}}};
  assign alloc_bit  = 64'd1 << fbit;

  // bits of the current word that fall inside the release range
  assign lb = (ptr[WA-1:0] == lo_r[IDX_W-1:6]) ? lo_r[5:0] : 6'd0;
  assign hb = (ptr[WA-1:0] == hi_r[IDX_W-1:6]) ? hi_r[5:0] : 6'd63;
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      rel_mask[b] = (6'(b) >= lb) && (6'(b) <= hb);
    end
  end

  assign rel_last   = ptr[WA-1:0] == hi_r[IDX_W-1:6];
  assign sweep_last = ptr[WA-1:0] == LAST_WORD;
  assign re_m1      = re - FN_W'(1);
  assign cand       = (rs > MAX_FN) ? MAX_FN : rs;
  assign base_fn    = FN_W'(base_r[63:FRAME_SHIFT]) + FN_W'(|base_r[FRAME_SHIFT-1:0]);

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = ptr[WA-1:0];
    wdata = '1;
    raddr = ptr[WA-1:0];
    unique case (cmd)
      CMD_SWEEP: begin
        we = 1'b1;
      end
      CMD_REL_WR: begin
        we    = 1'b1;
        wdata = rdata & ~rel_mask;
      end
      CMD_ALLOC_WR: begin
        we    = alloc_ok;
        waddr = fword;
        wdata = fdata | alloc_bit;
      end
      CMD_FREE_RD: begin
        raddr = free_word;
      end
      CMD_FREE_WR: begin
        we    = 1'b1;
        waddr = free_word;
        wdata = rdata & ~free_bit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fc       <= '0;
      ptr      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (cmd == CMD_SCAN) && (ptr < WORD_END);
      unique case (cmd)
        CMD_LOAD: begin
          ptr <= '0;
        end
        CMD_SWEEP, CMD_REL_WR: begin
          ptr <= ptr + 1'b1;
        end
        CMD_SCAN: begin
          if (ptr < WORD_END) begin
            ptr <= ptr + 1'b1;
          end
        end
        CMD_REL_SETUP: begin
          ptr <= (WA+1)'(rs[IDX_W-1:6]);
        end
        CMD_MEAS_UPD: begin
          if (cand > fc_ext) begin
            fc <= cand[FC_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_word_q <= ptr[WA-1:0];
    unique case (cmd)
      CMD_LOAD: begin
        op_r       <= operation;
        base_r     <= region_base;
        len_r      <= region_length;
        type_r     <= region_type;
        fidx_r     <= free_index;
        res_addr   <= '0;
        res_status <= STAT_OK;
      end
      CMD_MEAS_SUM: begin
        end_r <= base_r + 64'(len_r);
      end
      CMD_MEAS_ROUND: begin
        rs <= FN_W'(end_r[63:FRAME_SHIFT]) + FN_W'(|end_r[FRAME_SHIFT-1:0]);
      end
      CMD_REL_START: begin
        rs <= base_fn;
      end
      CMD_REL_STOP: begin
        re <= rs + FN_W'(len_r[31:FRAME_SHIFT]);
        if (rs < RES_FN) begin
          rs <= RES_FN;
        end
      end
      CMD_REL_CLIP: begin
        if (re > fc_ext) begin
          re <= fc_ext;
        end
      end
      CMD_REL_SETUP: begin
        lo_r <= rs[IDX_W-1:0];
        hi_r <= re_m1[IDX_W-1:0];
      end
      CMD_SCAN: begin
        if (scan_found) begin
          fbit  <= low_bit;
          fword <= rd_word_q;
          fdata <= rdata;
        end else if (scan_exhausted) begin
          res_status <= STAT_NO_FREE;
        end
      end
      CMD_ALLOC_WR: begin
        if (alloc_ok) begin
          res_addr <= alloc_wide[ADDR_W-1:0];
        end else begin
          res_status <= STAT_NO_FREE;
        end
      end
      CMD_FREE_RD: begin
        if (!free_in_range) begin
          res_status <= STAT_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.op             = op_r;
  assign stat.type_avail     = type_r == 32'd1;
  assign stat.sweep_last     = sweep_last;
  assign stat.rel_empty      = rs >= re;
  assign stat.rel_last       = rel_last;
  assign stat.scan_found     = scan_found;
  assign stat.scan_exhausted = scan_exhausted;
  assign stat.free_in_range  = free_in_range;

endmodule

### rtl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer of the allocator: steps the datapath through each operation.
// ----------------------------------------------------------------------------
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_ready,
  output logic     out_load
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (stat.op)
          OP_MEASURE:  state_next = ST_MEAS_SUM;
          OP_MARK_ALL: state_next = ST_MARK;
          OP_RELEASE:  state_next = stat.type_avail ? ST_REL_START : ST_DONE;
          OP_ALLOC:    state_next = ST_SCAN;
          OP_FREE:     state_next = ST_FREE_RD;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_MARK: begin
        if (stat.sweep_last) state_next = ST_DONE;
      end
      ST_MEAS_SUM:   state_next = ST_MEAS_ROUND;
      ST_MEAS_ROUND: state_next = ST_MEAS_UPD;
      ST_MEAS_UPD:   state_next = ST_DONE;
      ST_REL_START:  state_next = ST_REL_STOP;
      ST_REL_STOP:   state_next = ST_REL_CLIP;
      ST_REL_CLIP:   state_next = ST_REL_SETUP;
      ST_REL_SETUP:  state_next = stat.rel_empty ? ST_DONE : ST_REL_RD;
      ST_REL_RD:     state_next = ST_REL_WR;
      ST_REL_WR: begin
        state_next = stat.rel_last ? ST_DONE : ST_REL_RD;
      end
      ST_SCAN: begin
        priority if (stat.scan_found) state_next = ST_ALLOC_WR;
        else if (stat.scan_exhausted) state_next = ST_DONE;
      end
      ST_ALLOC_WR:   state_next = ST_DONE;
      ST_FREE_RD:    state_next = stat.free_in_range ? ST_FREE_WR : ST_DONE;
      ST_FREE_WR:    state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:       state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_CLEAR, ST_MARK: cmd = CMD_SWEEP;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      ST_MEAS_SUM:   cmd = CMD_MEAS_SUM;
      ST_MEAS_ROUND: cmd = CMD_MEAS_ROUND;
      ST_MEAS_UPD:   cmd = CMD_MEAS_UPD;
      ST_REL_START:  cmd = CMD_REL_START;
      ST_REL_STOP:   cmd = CMD_REL_STOP;
      ST_REL_CLIP:   cmd = CMD_REL_CLIP;
      ST_REL_SETUP:  cmd = CMD_REL_SETUP;
      ST_REL_RD:     cmd = CMD_RMW_RD;
      ST_REL_WR:     cmd = CMD_REL_WR;
      ST_SCAN:       cmd = CMD_SCAN;
      ST_ALLOC_WR:   cmd = CMD_ALLOC_WR;
      ST_FREE_RD:    cmd = CMD_FREE_RD;
      ST_FREE_WR:    cmd = CMD_FREE_WR;
      ST_DONE:       out_load = out_free;
      default: begin
      end
    endcase
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the bitmap frame allocator. A table of directed items
// covers the empty bitmap, count boundaries, address wrap and saturation,
// region clipping and the top frame; random sessions of mark all, measure,
// release, allocate and free items with random handshake gaps follow. Each
// result is checked against a fixed value or a bit-level allocator predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import bfa_pkg::*;

  localparam int          WORDS            = MAX_FRAMES_DEF / WORD_BITS;
  localparam int          RANDOM_ITEMS     = 555;
  localparam int          WATCHDOG_LIMIT   = 20000;
  localparam int          TAIL_CYCLES      = 2200;  // a release reads and rewrites every bitmap word it touches
  localparam int          NUM_DIRECTED     = 26;
  localparam logic [2:0]  OP_RESERVED      = 3'd7;
  localparam logic [31:0] REGION_AVAILABLE = 32'd1;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] base;
    logic [31:0] len;
    logic [31:0] kind;
    logic [15:0] fidx;
    logic        fixed_exp;
    logic [27:0] addr;
    status_t     st;
  } stim_row_t;

  typedef struct packed {
    logic [27:0] addr;
    status_t     st;
  } alloc_result_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata  = '0;  // region_base, region_length, region_type, free_index
  logic [2:0]   s_tuser  = '0;  // operation
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;        // frame_address, status, zero pad

  // allocator state as predicted from the accepted items
  logic [63:0]   used_words [WORDS];
  logic [16:0]   frame_total;
  alloc_result_t pending_results[$];
  int            held_frames[$];
  int            errors       = 0;
  int            ops_sent     = 0;
  int            quiet_cycles = 0;
  bit            quiet_idle   = 1'b0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_ALLOC,    64'h0, 32'h0, 32'h0, 16'h0, 1'b1, 28'h0, STAT_NO_FREE},
    '{OP_FREE,     64'h0, 32'h0, 32'h0, 16'h0, 1'b1, 28'h0, STAT_RANGE},
    '{OP_FREE,     '1, '1, '1, 16'hFFFF, 1'b1, 28'h0, STAT_RANGE},
    '{OP_RESERVED, '1, '1, '1, 16'hFFFF, 1'b1, 28'h0, STAT_OK},
    '{OP_MEASURE,  64'h0, 32'h0200_0000, 32'h0, 16'h0, 1'b1, 28'h0, STAT_OK},
    '{OP_RELEASE,  64'h0, 32'h0200_0000, 32'd2, 16'h0, 1'b1, 28'h0, STAT_OK},
    '{OP_RELEASE,  64'h0, 32'h0080_0000, REGION_AVAILABLE, 16'h0, 1'b1, 28'h0, STAT_OK},
    '{OP_ALLOC,    64'h0, 32'h0, 32'h0, 16'h0, 1'b1, 28'h040_0000, STAT_OK},
    '{OP_FREE,     64'h0, 32'h0, 32'h0, 16'd1024, 1'b1, 28'h0, STAT_OK},
    // second free of the same frame is harmless
    '{OP_FREE,     64'h0, 32'h0, 32'h0, 16'd1024, 1'b1, 28'h0, STAT_OK},
    '{OP_ALLOC,    64'h0, 32'h0, 32'h0, 16'h0, 1'b1, 28'h040_0000, STAT_OK},
    '{OP_FREE,     64'h0, 32'h0, 32'h0, 16'd8191, 1'b1, 28'h0, STAT_OK},
    '{OP_FREE,     64'h0, 32'h0, 32'h0, 16'd8192, 1'b1, 28'h0, STAT_RANGE},
    // unaligned base rounds up to the next frame
    '{OP_RELEASE,  64'h40_0001, 32'h2000, REGION_AVAILABLE, 16'h0, 1'b0, 28'h0, STAT_OK},
    // end address wraps to zero
    '{OP_MEASURE,  64'hFFFF_FFFF_FFFF_F000, 32'h1000, 32'h0, 16'h0, 1'b1, 28'h0, STAT_OK},
    // count saturates
    '{OP_MEASURE,  '1, '1, 32'h0, 16'h0, 1'b1, 28'h0, STAT_OK},
    '{OP_RELEASE,  '1, '1, '1, 16'h0, 1'b1, 28'h0, STAT_OK},
    '{OP_RELEASE,  64'hFFFF_FFFF_FFFF_F001, '1, REGION_AVAILABLE, 16'h0, 1'b1, 28'h0, STAT_OK},
    // start raised to the reserved boundary
    '{OP_RELEASE,  64'h1000, 32'h0040_1000, REGION_AVAILABLE, 16'h0, 1'b0, 28'h0, STAT_OK},
    '{OP_RELEASE,  64'h0, '1, REGION_AVAILABLE, 16'h0, 1'b0, 28'h0, STAT_OK},
    '{OP_ALLOC,    64'h0, 32'h0, 32'h0, 16'h0, 1'b1, 28'h040_0000, STAT_OK},
    '{OP_FREE,     64'h0, 32'h0, 32'h0, 16'hFFFF, 1'b1, 28'h0, STAT_OK},
    '{OP_MARK_ALL, 64'h0, 32'h0, 32'h0, 16'h0, 1'b1, 28'h0, STAT_OK},
    '{OP_RELEASE,  64'h0FFF_F000, 32'h1000, REGION_AVAILABLE, 16'h0, 1'b1, 28'h0, STAT_OK},
    '{OP_ALLOC,    64'h0, 32'h0, 32'h0, 16'h0, 1'b1, 28'hFFF_F000, STAT_OK},
    '{OP_ALLOC,    64'h0, 32'h0, 32'h0, 16'h0, 1'b1, 28'h0, STAT_NO_FREE}
  };

  bitmap_frame_allocator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return quiet_idle ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic alloc_result_t predict_allocator(input stim_row_t row);
    alloc_result_t res;
    logic [63:0]   stop_addr;
    logic [63:0]   frames;
    logic [63:0]   first;
    logic [63:0]   last;
    int            w;
    int            b;
    bit            hit;
    res.addr = '0;
    res.st   = STAT_OK;
    case (row.op)
      OP_MEASURE: begin
        stop_addr = row.base + 64'(row.len);
        frames = (stop_addr >> FRAME_SHIFT) + 64'(stop_addr[FRAME_SHIFT-1:0] != '0);
        if (frames > 64'(MAX_FRAMES_DEF)) frames = 64'(MAX_FRAMES_DEF);
        if (frames > 64'(frame_total)) frame_total = frames[16:0];
      end
      OP_MARK_ALL: begin
        foreach (used_words[i]) used_words[i] = '1;
      end
      OP_RELEASE: begin
        if (row.kind == REGION_AVAILABLE) begin
          first = (row.base >> FRAME_SHIFT) + 64'(row.base[FRAME_SHIFT-1:0] != '0);
          last  = first + 64'(row.len >> FRAME_SHIFT);
          if (first < 64'(RESERVED_LOW_DEF)) first = 64'(RESERVED_LOW_DEF);
          if (last > 64'(frame_total)) last = 64'(frame_total);
          while (first < last) begin
            used_words[first / WORD_BITS][first % WORD_BITS] = 1'b0;
            first++;
          end
        end
      end
      OP_ALLOC: begin
        hit    = 1'b0;
        res.st = STAT_NO_FREE;
        for (w = 0; w < WORDS && !hit; w++) begin
          if (used_words[w] != '1) begin
            hit = 1'b1;
            b   = 0;
            while (used_words[w][b]) b++;
            // lowest clear bit at or past the count means nothing is free
            if (w * WORD_BITS + b < frame_total) begin
              used_words[w][b] = 1'b1;
              res.addr = ADDR_W'((w * WORD_BITS + b) << FRAME_SHIFT);
              res.st   = STAT_OK;
            end
          end
        end
      end
      OP_FREE: begin
        if (row.fidx >= frame_total) res.st = STAT_RANGE;
        else used_words[row.fidx / WORD_BITS][row.fidx % WORD_BITS] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_row_t random_row(input logic [2:0] op);
    stim_row_t r;
    r.op        = op;
    r.base      = {$urandom, $urandom};
    r.len       = $urandom;
    r.kind      = $urandom;
    r.fidx      = 16'($urandom);
    r.fixed_exp = 1'b0;
    r.addr      = '0;
    r.st        = STAT_OK;
    return r;
  endfunction

  task automatic push_item(input stim_row_t row);
    int            gap;
    alloc_result_t want;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.op;
    s_tdata  <= {row.fidx, row.kind, row.len, row.base};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_allocator(row);
    if (row.op == OP_ALLOC && want.st == STAT_OK) held_frames.push_back(int'(want.addr >> FRAME_SHIFT));
    if (row.fixed_exp) begin
      want.addr = row.addr;
      want.st   = row.st;
    end
    pending_results.push_back(want);
    if (row.op <= OP_FREE) ops_sent++;
  endtask

  // hold the sender until every outstanding result has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    stim_row_t r;
    int        k;
    int        frame;
    foreach (used_words[i]) used_words[i] = '1;
    frame_total = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) push_item(directed_rows[i]);
    settle();

    ops_sent = 0;
    while (ops_sent < RANDOM_ITEMS) begin
      quiet_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) settle();
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(3, 6)) push_item(random_row(3'($urandom_range(0, 7))));
      end else begin
        if ($urandom_range(0, 5) == 0) push_item(random_row(OP_MARK_ALL));
        repeat ($urandom_range(1, 2)) begin
          r = random_row(OP_MEASURE);
          if ($urandom_range(0, 3) != 0) r.base = 64'($urandom_range(0, 32'h0FFF_FFFF));
          push_item(r);
        end
        repeat ($urandom_range(1, 3)) begin
          r     = random_row(OP_RELEASE);
          frame = $urandom_range(0, MAX_FRAMES_DEF - 1);
          r.base = (64'(frame) << FRAME_SHIFT);
          if ($urandom_range(0, 1) != 0) r.base += 64'($urandom_range(0, 4095));
          if ($urandom_range(0, 15) != 0)
            r.len = (32'($urandom_range(0, 256)) << FRAME_SHIFT) | 32'($urandom_range(0, 4095));
          if ($urandom_range(0, 4) != 0) r.kind = REGION_AVAILABLE;
          push_item(r);
        end
        repeat ($urandom_range(10, 30)) begin
          if ($urandom_range(0, 9) < 6) begin
            r = random_row(OP_ALLOC);
          end else begin
            r = random_row(OP_FREE);
            if (held_frames.size() != 0 && $urandom_range(0, 3) != 0) begin
              k      = $urandom_range(0, held_frames.size() - 1);
              r.fidx = 16'(held_frames[k]);
              held_frames.delete(k);
            end
          end
          push_item(r);
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : result_sink
    int            stall;
    alloc_result_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got frame_address %h status %0d",
                 $time, m_tdata[27:0], m_tdata[29:28]);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[27:0] !== want.addr) begin
          errors++;
          $display("%0t: frame_address expected %h got %h", $time, want.addr, m_tdata[27:0]);
        end
        if (m_tdata[29:28] !== want.st) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.st, m_tdata[29:28]);
        end
      end
    end
  end

  // no progress on either side for too long ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

endmodule
